// ----- design/kmeans_cluster_2d_core_macros.svh -----
// assertion macros for the k-means core
`ifndef KMEANS_CLUSTER_2D_CORE_MACROS_SVH
`define KMEANS_CLUSTER_2D_CORE_MACROS_SVH
`ifndef SYNTHESIS
// combinational property checked at every edge
`define KMC_ASSERT_NOW(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error("kmeans core check failed");
// antecedent implies consequent in the next cycle
`define KMC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("kmeans core sequence check failed");
`else
`define KMC_ASSERT_NOW(lbl, ck, rn, prop)
`define KMC_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ----- design/kmc_pkg.sv -----
`default_nettype none
package kmc_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int MAX_CLUSTERS = 8;
    localparam int COORD_WIDTH  = 16;

    localparam int PT_AW    = $clog2(MAX_POINTS);
    localparam int CL_AW    = $clog2(MAX_CLUSTERS);
    localparam int IDX_W    = 10;
    localparam int LABEL_W  = 3;
    localparam int K_W      = 4;
    localparam int N_W      = 11;
    localparam int ITER_W   = 10;
    localparam int SUM_W    = 26;
    localparam int CNT_W    = 11;
    localparam int DIV_W    = SUM_W + 1;
    localparam int DIFF_W   = COORD_WIDTH + 1;
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int DIST_W   = SQ_W + 1;
    localparam int DCNT_W   = $clog2(DIV_W + 1);
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    typedef enum logic [1:0] {
        OP_LOAD_POINT    = 2'd0,
        OP_LOAD_CENTROID = 2'd1,
        OP_RUN           = 2'd2,
        OP_READ_LABEL    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        REG_NUM_CLUSTERS   = 2'd0,
        REG_NUM_POINTS     = 2'd1,
        REG_MAX_ITERATIONS = 2'd2,
        REG_NONE           = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]                     opcode;
        logic [IDX_W-1:0]               item_index;
        logic signed [COORD_WIDTH-1:0]  coord_x;
        logic signed [COORD_WIDTH-1:0]  coord_y;
        logic [LABEL_W-1:0]             initial_label;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]               out_index;
        logic signed [COORD_WIDTH-1:0]  out_x;
        logic signed [COORD_WIDTH-1:0]  out_y;
        logic [LABEL_W-1:0]             out_label;
        logic [ITER_W-1:0]              passes_done;
        logic                           converged;
        logic                           last;
    } rsp_t;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [CNT_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_W-1:0]   quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

// ----- design/kmc_ram.sv -----
`default_nettype none
module kmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- design/kmc_div.sv -----
`default_nettype none
module kmc_div
    import kmc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire div_req_t req,
    output div_rsp_t  rsp
);

    logic [DIV_W-1:0]  dq_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W:0]    trial;
    logic              fits;

    // restoring step: one quotient bit a cycle
    assign trial = {rem_reg, dq_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == DCNT_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DCNT_W'(1);
                if (cnt_reg == DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dq_reg  <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? CNT_W'(trial - {1'b0, dvs_reg}) : trial[CNT_W-1:0];
            dq_reg  <= {dq_reg[DIV_W-2:0], fits};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;

endmodule
`default_nettype wire

// ----- design/kmeans_cluster_2d_core.sv -----
`default_nettype none
// channel   dir  handshake             payload
// cmd       in   cmd_valid/cmd_stall   cmd_t (opcode, index, x, y, label)
// rsp       out  rsp_valid/rsp_stall   rsp_t (index, x, y, label, passes, ...)
// apb       in   psel/penable/pready   num_clusters, num_points, max_iterations
//
// a load is taken while the core stays in ST_IDLE; a label read waits in ST_RDLB for the output
// a run takes each point through ST_RDPT and ST_LATCH, then ST_MULX, ST_MULY and ST_CMP per
// candidate on the one shared multiplier, then ST_WRLB; each pass then uses the serial divider
// cmd_stall stays high while a run or read is under way or its results wait
// reset clears centroids, sums and counts; point and label stores are not cleared
`include "kmeans_cluster_2d_core_macros.svh"
module kmeans_cluster_2d_core
    import kmc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire cmd_t               cmd,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output rsp_t                    rsp
);

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_RDPT    = 13'b0000000000010,
        ST_LATCH   = 13'b0000000000100,
        ST_MULX    = 13'b0000000001000,
        ST_MULY    = 13'b0000000010000,
        ST_CMP     = 13'b0000000100000,
        ST_WRLB    = 13'b0000001000000,
        ST_UPD     = 13'b0000010000000,
        ST_DIVX    = 13'b0000100000000,
        ST_DIVY    = 13'b0001000000000,
        ST_PASSEND = 13'b0010000000000,
        ST_EMIT    = 13'b0100000000000,
        ST_RDLB    = 13'b1000000000000
    } state_t;

    state_t state_reg;

    logic [K_W-1:0]    k_cfg_reg;
    logic [N_W-1:0]    n_cfg_reg;
    logic [ITER_W-1:0] lim_cfg_reg;
    logic [K_W-1:0]    k_eff;
    logic [N_W-1:0]    n_eff;
    logic [ITER_W-1:0] lim_eff;
    logic [K_W-1:0]    k_last;

    logic signed [COORD_WIDTH-1:0] cen_x_reg [MAX_CLUSTERS];
    logic signed [COORD_WIDTH-1:0] cen_y_reg [MAX_CLUSTERS];
    logic signed [SUM_W-1:0]       sum_x_reg [MAX_CLUSTERS];
    logic signed [SUM_W-1:0]       sum_y_reg [MAX_CLUSTERS];
    logic [CNT_W-1:0]              cnt_reg   [MAX_CLUSTERS];

    logic [N_W-1:0]    i_reg;
    logic [N_W-1:0]    i_next;
    logic [CL_AW-1:0]  c_reg;
    logic [CL_AW-1:0]  cand_reg;
    logic [CL_AW-1:0]  lab_reg;
    logic [CL_AW-1:0]  u_reg;
    logic [CL_AW-1:0]  e_reg;
    logic              first_reg;
    logic              changed_reg;
    logic [ITER_W-1:0] pass_reg;
    logic [ITER_W-1:0] pass_next;
    logic [IDX_W-1:0]  ridx_reg;
    logic [LABEL_W-1:0] rlab_reg;
    logic              rd_first_reg;

    logic signed [COORD_WIDTH-1:0] px_reg;
    logic signed [COORD_WIDTH-1:0] py_reg;
    logic [SQ_W-1:0]   sqx_reg;
    logic [SQ_W-1:0]   sqy_reg;
    logic [DIST_W-1:0] best_reg;
    logic [DIST_W-1:0] dist_sum;

    logic               cmd_acc;
    logic               rsp_acc;
    logic               cfg_wr;

    logic               pt_we;
    logic [PT_AW-1:0]   pt_waddr;
    logic [2*COORD_WIDTH-1:0] pt_wdata;
    logic [PT_AW-1:0]   rd_addr;
    logic [2*COORD_WIDTH-1:0] pt_rdata;
    logic               lb_we;
    logic [LABEL_W-1:0] lb_wdata;
    logic [LABEL_W-1:0] lb_rdata;

    logic [CL_AW-1:0]   cen_sel;
    logic signed [COORD_WIDTH-1:0] cx_sel;
    logic signed [COORD_WIDTH-1:0] cy_sel;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]  mag;
    logic [SQ_W-1:0]    prod;

    logic [CL_AW-1:0]   sum_sel;
    logic signed [SUM_W-1:0] sx_sel;
    logic signed [SUM_W-1:0] sy_sel;
    logic [CNT_W-1:0]   cnt_sel;
    logic signed [SUM_W-1:0] sum_op;
    logic [SUM_W-1:0]   sum_mag;
    logic signed [COORD_WIDTH-1:0] mean;
    logic [COORD_WIDTH-1:0] qlow;
    logic               lab_in_use;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // handshakes
    assign cmd_stall = (state_reg != ST_IDLE);
    assign cmd_acc   = cmd_valid && !cmd_stall;
    assign rsp_valid = (state_reg == ST_EMIT) || (state_reg == ST_RDLB);
    assign rsp_acc   = rsp_valid && !rsp_stall;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_cfg_reg   <= K_W'(3);
            n_cfg_reg   <= N_W'(1024);
            lim_cfg_reg <= ITER_W'(256);
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_NUM_CLUSTERS:   k_cfg_reg   <= pwdata[K_W-1:0];
                REG_NUM_POINTS:     n_cfg_reg   <= pwdata[N_W-1:0];
                REG_MAX_ITERATIONS: lim_cfg_reg <= pwdata[ITER_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_NUM_CLUSTERS:   prdata = PDATA_W'(k_cfg_reg);
            REG_NUM_POINTS:     prdata = PDATA_W'(n_cfg_reg);
            REG_MAX_ITERATIONS: prdata = PDATA_W'(lim_cfg_reg);
            default:            prdata = '0;
        endcase
    end

    // effective run limits
    always_comb
    begin
        if (k_cfg_reg == '0)
            k_eff = K_W'(1);
        else if (k_cfg_reg > K_W'(MAX_CLUSTERS))
            k_eff = K_W'(MAX_CLUSTERS);
        else
            k_eff = k_cfg_reg;
        n_eff   = (n_cfg_reg > N_W'(MAX_POINTS)) ? N_W'(MAX_POINTS) : n_cfg_reg;
        lim_eff = (lim_cfg_reg == '0) ? ITER_W'(1) : lim_cfg_reg;
        k_last  = k_eff - K_W'(1);
    end

    // point and label stores
    assign pt_we    = cmd_acc && (opcode_t'(cmd.opcode) == OP_LOAD_POINT);
    assign pt_waddr = cmd.item_index[PT_AW-1:0];
    assign pt_wdata = {cmd.coord_x, cmd.coord_y};
    assign rd_addr  = (state_reg == ST_IDLE) ? cmd.item_index[PT_AW-1:0]
                                              : i_reg[PT_AW-1:0];
    assign lb_we    = pt_we || (state_reg == ST_WRLB);
    assign lb_wdata = pt_we ? cmd.initial_label : LABEL_W'(lab_reg);

    kmc_ram #(.WIDTH(2 * COORD_WIDTH), .DEPTH(MAX_POINTS)) u_pt_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .raddr (rd_addr),
        .rdata (pt_rdata)
    );

    kmc_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_POINTS)) u_lb_ram (
        .clk   (clk),
        .we    (lb_we),
        .waddr ((state_reg == ST_WRLB) ? i_reg[PT_AW-1:0] : pt_waddr),
        .wdata (lb_wdata),
        .raddr (rd_addr),
        .rdata (lb_rdata)
    );

    // shared squaring unit
    assign cen_sel = (state_reg == ST_EMIT) ? e_reg : cand_reg;
    assign cx_sel  = cen_x_reg[cen_sel];
    assign cy_sel  = cen_y_reg[cen_sel];
    assign diff    = (state_reg == ST_MULX)
                   ? (DIFF_W'(cx_sel) - DIFF_W'(px_reg))
                   : (DIFF_W'(cy_sel) - DIFF_W'(py_reg));
    assign mag     = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign prod    = mag * mag;
    assign dist_sum = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);

    // cluster sums and rounding divide
    assign sum_sel    = (state_reg == ST_WRLB) ? lab_reg : u_reg;
    assign sx_sel     = sum_x_reg[sum_sel];
    assign sy_sel     = sum_y_reg[sum_sel];
    assign cnt_sel    = cnt_reg[sum_sel];
    assign lab_in_use = {1'b0, lab_reg} < k_eff;
    assign sum_op     = (state_reg == ST_UPD) ? sx_sel : sy_sel;
    assign sum_mag    = sum_op[SUM_W-1] ? SUM_W'(-sum_op) : SUM_W'(sum_op);

    assign div_req.start    = ((state_reg == ST_UPD) && (cnt_sel != '0))
                           || ((state_reg == ST_DIVX) && div_rsp.done);
    assign div_req.dividend = DIV_W'(sum_mag) + DIV_W'(cnt_sel >> 1);
    assign div_req.divisor  = cnt_sel;

    kmc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign qlow = div_rsp.quotient[COORD_WIDTH-1:0];
    assign mean = ((state_reg == ST_DIVX) ? sx_sel[SUM_W-1] : sy_sel[SUM_W-1])
                ? COORD_WIDTH'(-qlow) : COORD_WIDTH'(qlow);

    assign i_next    = i_reg + N_W'(1);
    assign pass_next = pass_reg + ITER_W'(1);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            c_reg       <= '0;
            cand_reg    <= '0;
            lab_reg     <= '0;
            u_reg       <= '0;
            e_reg       <= '0;
            first_reg   <= 1'b0;
            changed_reg <= 1'b0;
            pass_reg    <= '0;
            for (int j = 0; j < MAX_CLUSTERS; j++)
            begin
                cen_x_reg[j] <= '0;
                cen_y_reg[j] <= '0;
                sum_x_reg[j] <= '0;
                sum_y_reg[j] <= '0;
                cnt_reg[j]   <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_acc)
                    begin
                        unique case (opcode_t'(cmd.opcode))
                            OP_LOAD_POINT:
                            begin
                            end
                            OP_LOAD_CENTROID:
                            begin
                                if (cmd.item_index < IDX_W'(MAX_CLUSTERS))
                                begin
                                    cen_x_reg[cmd.item_index[CL_AW-1:0]] <= cmd.coord_x;
                                    cen_y_reg[cmd.item_index[CL_AW-1:0]] <= cmd.coord_y;
                                end
                            end
                            OP_RUN:
                            begin
                                pass_reg    <= '0;
                                changed_reg <= 1'b0;
                                i_reg       <= '0;
                                u_reg       <= '0;
                                for (int j = 0; j < MAX_CLUSTERS; j++)
                                begin
                                    sum_x_reg[j] <= '0;
                                    sum_y_reg[j] <= '0;
                                    cnt_reg[j]   <= '0;
                                end
                                state_reg <= (n_eff == '0) ? ST_UPD : ST_RDPT;
                            end
                            OP_READ_LABEL:
                            begin
                                state_reg <= ST_RDLB;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_RDPT:
                begin
                    state_reg <= ST_LATCH;
                end
                ST_LATCH:
                begin
                    px_reg    <= pt_rdata[2*COORD_WIDTH-1:COORD_WIDTH];
                    py_reg    <= pt_rdata[COORD_WIDTH-1:0];
                    lab_reg   <= lb_rdata;
                    cand_reg  <= lb_rdata;
                    c_reg     <= '0;
                    first_reg <= 1'b1;
                    state_reg <= ST_MULX;
                end
                ST_MULX:
                begin
                    sqx_reg   <= prod;
                    state_reg <= ST_MULY;
                end
                ST_MULY:
                begin
                    sqy_reg   <= prod;
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    if (first_reg)
                    begin
                        // distance to the current centroid
                        best_reg  <= dist_sum;
                        first_reg <= 1'b0;
                        cand_reg  <= '0;
                        state_reg <= ST_MULX;
                    end
                    else
                    begin
                        if (dist_sum < best_reg)
                        begin
                            best_reg    <= dist_sum;
                            lab_reg     <= c_reg;
                            changed_reg <= 1'b1;
                        end
                        if ({1'b0, c_reg} == k_last)
                        begin
                            state_reg <= ST_WRLB;
                        end
                        else
                        begin
                            c_reg     <= c_reg + CL_AW'(1);
                            cand_reg  <= c_reg + CL_AW'(1);
                            state_reg <= ST_MULX;
                        end
                    end
                end
                ST_WRLB:
                begin
                    // fold the point into its cluster
                    if (lab_in_use)
                    begin
                        sum_x_reg[lab_reg] <= sx_sel + SUM_W'(px_reg);
                        sum_y_reg[lab_reg] <= sy_sel + SUM_W'(py_reg);
                        cnt_reg[lab_reg]   <= cnt_sel + CNT_W'(1);
                    end
                    i_reg <= i_next;
                    if (i_next < n_eff)
                    begin
                        state_reg <= ST_RDPT;
                    end
                    else
                    begin
                        u_reg     <= '0;
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD:
                begin
                    if (cnt_sel != '0)
                    begin
                        state_reg <= ST_DIVX;
                    end
                    else if ({1'b0, u_reg} == k_last)
                    begin
                        state_reg <= ST_PASSEND;
                    end
                    else
                    begin
                        u_reg <= u_reg + CL_AW'(1);
                    end
                end
                ST_DIVX:
                begin
                    if (div_rsp.done)
                    begin
                        cen_x_reg[u_reg] <= mean;
                        state_reg        <= ST_DIVY;
                    end
                end
                ST_DIVY:
                begin
                    if (div_rsp.done)
                    begin
                        cen_y_reg[u_reg] <= mean;
                        if ({1'b0, u_reg} == k_last)
                        begin
                            state_reg <= ST_PASSEND;
                        end
                        else
                        begin
                            u_reg     <= u_reg + CL_AW'(1);
                            state_reg <= ST_UPD;
                        end
                    end
                end
                ST_PASSEND:
                begin
                    pass_reg <= pass_next;
                    if (changed_reg && (pass_next < lim_eff))
                    begin
                        changed_reg <= 1'b0;
                        i_reg       <= '0;
                        for (int j = 0; j < MAX_CLUSTERS; j++)
                        begin
                            sum_x_reg[j] <= '0;
                            sum_y_reg[j] <= '0;
                            cnt_reg[j]   <= '0;
                        end
                        state_reg <= ST_RDPT;
                    end
                    else
                    begin
                        e_reg     <= '0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (rsp_acc)
                    begin
                        if ({1'b0, e_reg} == k_last)
                            state_reg <= ST_IDLE;
                        else
                            e_reg <= e_reg + CL_AW'(1);
                    end
                end
                ST_RDLB:
                begin
                    if (rsp_acc)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // label read: the registered store read returns the data in the cycle after the address
    always_ff @(posedge clk)
    begin
        if (cmd_acc)
            ridx_reg <= cmd.item_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_first_reg <= 1'b0;
            rlab_reg     <= '0;
        end
        else
        begin
            rd_first_reg <= cmd_acc && (opcode_t'(cmd.opcode) == OP_READ_LABEL);
            if (rd_first_reg)
                rlab_reg <= lb_rdata;
        end
    end

    // result item
    always_comb
    begin
        rsp = '0;
        if (state_reg == ST_EMIT)
        begin
            rsp.out_index   = IDX_W'(e_reg);
            rsp.out_x       = cx_sel;
            rsp.out_y       = cy_sel;
            rsp.passes_done = pass_reg;
            rsp.converged   = !changed_reg;
            rsp.last        = ({1'b0, e_reg} == k_last);
        end
        else
        begin
            rsp.out_index = ridx_reg;
            rsp.out_label = rd_first_reg ? lb_rdata : rlab_reg;
            rsp.last      = 1'b1;
        end
    end

    // checks
    `KMC_ASSERT_NOW(a_no_take_while_out, clk, rst_n, !rsp_valid || cmd_stall)
    `KMC_ASSERT_NOW(a_pass_under_limit, clk, rst_n,
        (state_reg != ST_PASSEND) || (pass_reg < lim_eff))
    `KMC_ASSERT_NOW(a_div_in_update, clk, rst_n,
        !div_rsp.busy || (state_reg == ST_DIVX) || (state_reg == ST_DIVY))
    `KMC_ASSERT_NEXT(a_run_leaves_idle, clk, rst_n,
        cmd_acc && (cmd.opcode == OP_RUN), cmd_stall)

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import kmc_pkg::*;

    // point entries written at the start; runs and random reads stay inside them
    localparam int FILL_PTS = 16;

    // expected-result store and bit-true clustering predictor
    class kmeans_scoreboard;
        logic signed [COORD_WIDTH-1:0] pt_x [MAX_POINTS];
        logic signed [COORD_WIDTH-1:0] pt_y [MAX_POINTS];
        logic [LABEL_W-1:0]            pt_label [MAX_POINTS];
        logic signed [COORD_WIDTH-1:0] cen_x [MAX_CLUSTERS];
        logic signed [COORD_WIDTH-1:0] cen_y [MAX_CLUSTERS];
        logic [K_W-1:0]                k_reg;
        logic [N_W-1:0]                n_reg;
        logic [ITER_W-1:0]             iter_reg;
        rsp_t                          pending [$];
        int                            errors;
        int                            checked;
        int                            runs;

        function new();
            for (int c = 0; c < MAX_CLUSTERS; c++)
            begin
                cen_x[c] = '0;
                cen_y[c] = '0;
            end
            k_reg    = 4'd3;
            n_reg    = 11'd1024;
            iter_reg = 10'd256;
            errors   = 0;
            checked  = 0;
            runs     = 0;
        endfunction

        task report(string msg);
            $display("mismatch @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function void set_reg(reg_idx_t r, logic [PDATA_W-1:0] v);
            case (r)
                REG_NUM_CLUSTERS:   k_reg = v[K_W-1:0];
                REG_NUM_POINTS:     n_reg = v[N_W-1:0];
                REG_MAX_ITERATIONS: iter_reg = v[ITER_W-1:0];
                default: ;
            endcase
        endfunction

        function longint sq_dist(int c, int i);
            longint dx;
            longint dy;
            dx = longint'(cen_x[c]) - longint'(pt_x[i]);
            dy = longint'(cen_y[c]) - longint'(pt_y[i]);
            return dx * dx + dy * dy;
        endfunction

        // mean rounded to nearest, ties away from zero
        function longint rounded_mean(longint s, int cnt);
            longint a;
            longint q;
            a = (s < 0) ? -s : s;
            q = (a + cnt / 2) / cnt;
            return (s < 0) ? -q : q;
        endfunction

        function void cluster_run();
            int k;
            int n;
            int lim;
            int passes;
            int changed;
            int lab;
            int cnt;
            longint sx;
            longint sy;
            rsp_t r;
            k   = (k_reg < 1) ? 1 : ((k_reg > 8) ? 8 : k_reg);
            n   = (n_reg > MAX_POINTS) ? MAX_POINTS : n_reg;
            lim = (iter_reg == 0) ? 1 : iter_reg;
            passes = 0;
            do
            begin
                changed = 0;
                // assign step: strictly closer only, scanning in order
                for (int i = 0; i < n; i++)
                begin
                    lab = pt_label[i];
                    for (int c = 0; c < k; c++)
                    begin
                        if (sq_dist(c, i) < sq_dist(lab, i))
                        begin
                            lab = c;
                            changed++;
                        end
                    end
                    pt_label[i] = lab[LABEL_W-1:0];
                end
                // update step: empty clusters keep their centroid
                for (int c = 0; c < k; c++)
                begin
                    sx  = 0;
                    sy  = 0;
                    cnt = 0;
                    for (int i = 0; i < n; i++)
                    begin
                        if (pt_label[i] == c)
                        begin
                            sx += longint'(pt_x[i]);
                            sy += longint'(pt_y[i]);
                            cnt++;
                        end
                    end
                    if (cnt != 0)
                    begin
                        cen_x[c] = rounded_mean(sx, cnt);
                        cen_y[c] = rounded_mean(sy, cnt);
                    end
                end
                passes++;
            end
            while (changed != 0 && passes < lim);
            for (int c = 0; c < k; c++)
            begin
                r.out_index   = c;
                r.out_x       = cen_x[c];
                r.out_y       = cen_y[c];
                r.out_label   = '0;
                r.passes_done = passes;
                r.converged   = (changed == 0);
                r.last        = (c + 1 == k);
                pending.push_back(r);
            end
            runs++;
        endfunction

        function void note_cmd(cmd_t cm);
            rsp_t r;
            case (opcode_t'(cm.opcode))
                OP_LOAD_POINT:
                begin
                    pt_x[cm.item_index]     = cm.coord_x;
                    pt_y[cm.item_index]     = cm.coord_y;
                    pt_label[cm.item_index] = cm.initial_label;
                end
                OP_LOAD_CENTROID:
                begin
                    if (cm.item_index < MAX_CLUSTERS)
                    begin
                        cen_x[cm.item_index] = cm.coord_x;
                        cen_y[cm.item_index] = cm.coord_y;
                    end
                end
                OP_RUN:
                    cluster_run();
                default:
                begin
                    r             = '0;
                    r.out_index   = cm.item_index;
                    r.out_label   = pt_label[cm.item_index];
                    r.last        = 1'b1;
                    pending.push_back(r);
                end
            endcase
        endfunction

        task check(rsp_t got);
            rsp_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("result with nothing expected, index %0d", got.out_index));
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.out_index !== want.out_index)
                report($sformatf("out_index %0d, want %0d", got.out_index, want.out_index));
            if (got.out_x !== want.out_x)
                report($sformatf("out_x %0d, want %0d", got.out_x, want.out_x));
            if (got.out_y !== want.out_y)
                report($sformatf("out_y %0d, want %0d", got.out_y, want.out_y));
            if (got.out_label !== want.out_label)
                report($sformatf("out_label %0d, want %0d", got.out_label, want.out_label));
            if (got.passes_done !== want.passes_done)
                report($sformatf("passes_done %0d, want %0d",
                                 got.passes_done, want.passes_done));
            if (got.converged !== want.converged)
                report($sformatf("converged %0b, want %0b", got.converged, want.converged));
            if (got.last !== want.last)
                report($sformatf("last %0b, want %0b", got.last, want.last));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 cmd_valid = 1'b0;
    logic                 cmd_stall;
    cmd_t                 cmd = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_t                 rsp;

    kmeans_cluster_2d_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    kmeans_scoreboard sb = new();
    bit quiet = 1'b0;
    int hold_count = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int burst_left = 0;
    int items_sent = 0;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stall bursts, one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_count != hold_seen)
        begin
            hold_seen <= hold_count;
            hold_left <= 400;
            rsp_stall <= 1'b1;
        end
        else if (quiet)
            rsp_stall <= 1'b0;
        else if (burst_left > 0)
            burst_left <= burst_left - 1;
        else
        begin
            rsp_stall  <= ($urandom_range(0, 2) == 0);
            burst_left <= $urandom_range(0, 7);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check(rsp);
    end

    task automatic apb_write(reg_idx_t r, logic [PDATA_W-1:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(r * 4);
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(r, v);
    endtask

    task automatic set_config(int k, int n, int it);
        apb_write(REG_NUM_CLUSTERS, k);
        apb_write(REG_NUM_POINTS, n);
        apb_write(REG_MAX_ITERATIONS, it);
    endtask

    // offer one item, hold it until accepted, then an optional gap
    task automatic send_item(cmd_t cm);
        int gap;
        cmd       <= cm;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sb.note_cmd(cm);
        items_sent++;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_fields(opcode_t op, int idx, logic [15:0] x, logic [15:0] y,
                               int lab);
        cmd_t cm;
        cm.opcode        = op;
        cm.item_index    = idx;
        cm.coord_x       = x;
        cm.coord_y       = y;
        cm.initial_label = lab;
        send_item(cm);
    endtask

    // wait until every expected result is in, then let loads settle
    task automatic drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // random item, mostly touching the points that take part in runs
    task automatic random_item(int npts);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            send_fields(OP_LOAD_POINT, $urandom_range(0, npts), $urandom(), $urandom(),
                        $urandom_range(0, 7));
        else if (sel < 48)
            send_fields(OP_LOAD_POINT, $urandom_range(0, 1023), $urandom(), $urandom(),
                        $urandom_range(0, 7));
        else if (sel < 63)
            send_fields(OP_LOAD_CENTROID,
                        ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, 7),
                        $urandom(), $urandom(), $urandom_range(0, 7));
        else if (sel < 74)
            send_fields(OP_RUN, $urandom_range(0, 1023), $urandom(), $urandom(),
                        $urandom_range(0, 7));
        else
            send_fields(OP_READ_LABEL,
                        ($urandom_range(0, 1) == 0) ? $urandom_range(0, npts)
                                                    : $urandom_range(0, FILL_PTS - 1),
                        $urandom(), $urandom(), $urandom_range(0, 7));
    endtask

    // main sequence
    initial
    begin
        int k;
        int n;
        int it;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the low point entries so no run or read sees an unwritten one
        quiet = 1'b1;
        for (int i = 0; i < FILL_PTS; i++)
            send_fields(OP_LOAD_POINT, i, $urandom(), $urandom(), $urandom_range(0, 7));
        drain();
        quiet = 1'b0;

        // directed: extremes, ignored centroid loads, top point entry
        set_config(8, FILL_PTS, 1);
        send_fields(OP_LOAD_CENTROID, 0, 16'h8000, 16'h8000, 0);
        send_fields(OP_LOAD_CENTROID, 1, 16'h7fff, 16'h7fff, 7);
        send_fields(OP_LOAD_CENTROID, 2, 16'h8000, 16'h7fff, 0);
        send_fields(OP_LOAD_CENTROID, 3, 16'h7fff, 16'h8000, 0);
        send_fields(OP_LOAD_CENTROID, 8, 16'h1234, 16'h4321, 0);
        send_fields(OP_LOAD_CENTROID, 1023, 16'hffff, 16'hffff, 7);
        send_fields(OP_LOAD_POINT, 0, 16'h8000, 16'h7fff, 7);
        send_fields(OP_LOAD_POINT, 1023, 16'h7fff, 16'h8000, 5);
        send_fields(OP_RUN, 0, 16'h0, 16'h0, 0);
        send_fields(OP_READ_LABEL, 0, 16'h0, 16'h0, 0);
        send_fields(OP_READ_LABEL, 1023, 16'hffff, 16'hffff, 7);
        drain();

        // zero registers: one cluster, no points, one pass
        set_config(0, 0, 0);
        send_fields(OP_RUN, 1023, 16'h0, 16'h0, 0);
        send_fields(OP_READ_LABEL, 5, 16'h0, 16'h0, 0);
        drain();

        // clusters above limit, ties between equal distances, starting labels 6 and 7
        set_config(15, 4, 1023);
        send_fields(OP_LOAD_CENTROID, 0, 16'h0100, 16'h0000, 0);
        send_fields(OP_LOAD_CENTROID, 1, 16'hff00, 16'h0000, 0);
        send_fields(OP_LOAD_POINT, 0, 16'h0000, 16'h0000, 6);
        send_fields(OP_LOAD_POINT, 1, 16'h0000, 16'h0000, 7);
        send_fields(OP_LOAD_POINT, 2, 16'h0300, 16'h0001, 0);
        send_fields(OP_LOAD_POINT, 3, 16'hfd00, 16'hffff, 1);
        send_fields(OP_RUN, 0, 16'h0, 16'h0, 0);
        send_fields(OP_READ_LABEL, 0, 16'h0, 16'h0, 0);
        send_fields(OP_READ_LABEL, 1, 16'h0, 16'h0, 0);
        drain();

        // random phases, each with its own register setting
        for (int ph = 0; ph < 8; ph++)
        begin
            k  = ($urandom_range(0, 5) == 0) ? (($urandom_range(0, 1) == 0) ? 0 : 15)
                                             : $urandom_range(1, 8);
            n  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
            it = ($urandom_range(0, 5) == 0) ? (($urandom_range(0, 1) == 0) ? 0 : 1023)
                                             : $urandom_range(1, 30);
            set_config(k, n, it);
            if (ph == 2)
                hold_count++;
            if (ph == 7)
                quiet = 1'b1;
            for (int j = 0; j < 46; j++)
                random_item(n);
            drain();
        end

        repeat (50) @(posedge clk);
        $display("covered %0d items, %0d runs, %0d results checked",
                 items_sent, sb.runs, sb.checked);
        $display("register settings included zero, oversized and limit values");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // overall time limit
    initial
    begin
        #2_000_000_000;
        $display("timeout with %0d results outstanding", sb.pending.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire
